// File: design/pvir_pkg.sv
// Shared types, constants and helpers for the variable-rate PID controller.
// Used by pvir_mac, pvir_div and pid_variable_integration_rate; no dependencies.
`timescale 1ns / 1ps

package pvir_pkg;

  localparam int DATA_W   = 32;             // sample and result width
  localparam int FRAC_W   = 16;             // fraction bits of Q16.16
  localparam int REG_W    = 31;             // unsigned register width
  localparam int MUL_A_W  = 49;             // signed operand of the shared multiplier
  localparam int MUL_B_W  = 16;             // unsigned operand (one gain chunk)
  localparam int ACC_W    = 64;             // multiply-accumulate width
  localparam int DIV_Q_W  = FRAC_W;         // fade factor bits
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);
  localparam int SUM_W    = 50;             // width handed to the clamp
  localparam int CFG_A_W  = 3;

  typedef enum logic [CFG_A_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4,
    REG_VARY_EN     = 3'd5,
    REG_THRESH_A    = 3'd6,
    REG_THRESH_B    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for an item
    S_P0,     // gain_p low chunk
    S_P1,     // gain_p high chunk
    S_I0,     // gain_i low chunk, take P
    S_I1,     // gain_i high chunk
    S_D0,     // gain_d low chunk, take increment
    S_D1,     // gain_d high chunk
    S_VR,     // take D, decide on rate scaling
    S_DIV,    // fade factor division
    S_SC,     // increment times factor
    S_SCW,    // take scaled increment
    S_INT,    // update and clamp integral
    S_SUM,    // sum and clamp output
    S_OUT     // hand over to output register
  } state_t;

  typedef struct packed {
    logic en;
    logic clear;     // start a new sum instead of accumulating
    logic shift_hi;  // weight the product by 2^MUL_B_W
  } mac_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Symmetric clamp: x <= -lim gives -lim, x >= lim gives lim.
  function automatic logic signed [DATA_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] x,
    input logic [REG_W-1:0]        lim
  );
    logic signed [SUM_W-1:0]  lim_s;
    logic signed [SUM_W-1:0]  neg_s;
    logic signed [DATA_W-1:0] r;
    lim_s = $signed({{(SUM_W-REG_W){1'b0}}, lim});
    neg_s = -lim_s;
    if (x <= neg_s) begin
      r = neg_s[DATA_W-1:0];
    end else if (x >= lim_s) begin
      r = lim_s[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/pid_variable_integration_rate.sv
// Positional PID controller with trapezoidal integral and variable integration
// rate. Depends on pvir_pkg, pvir_mac and pvir_div.
//
//  channel | signals                              | item
//  --------+--------------------------------------+-------------------------------
//  input   | in_tvalid, in_tready, in_tdata[63:0] | target, feedback
//  output  | out_tvalid, out_tready, out_tdata    | drive, integral_value
//  config  | cfg_wr_en, cfg_addr, cfg_wdata[30:0] | eight registers, write only
//
// An item takes the division steps only when the fade zone applies; a new
// item can be taken the cycle after the result is handed over.
// The shared multiplier takes three gains in two 16-bit chunks each, and the
// fade factor comes from a divider yielding one bit per cycle.
// rst_n clears the configuration, the error history and the integral.
// A stalled output item holds; the next item is still taken and worked on,
// and its result waits in the sequencer until the output register frees.
`timescale 1ns / 1ps

module pid_variable_integration_rate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] target, [63:32] feedback
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] drive, [63:32] integral_value
  input  logic        cfg_wr_en,
  input  logic [pvir_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [pvir_pkg::REG_W-1:0]   cfg_wdata
);

  localparam int DW   = pvir_pkg::DATA_W;
  localparam int FW   = pvir_pkg::FRAC_W;
  localparam int RW   = pvir_pkg::REG_W;
  localparam int AW   = pvir_pkg::MUL_A_W;
  localparam int BW   = pvir_pkg::MUL_B_W;
  localparam int TW   = 48;     // P and D terms
  localparam int IW   = 47;     // integral increment
  localparam int SW   = pvir_pkg::SUM_W;

  // configuration
  logic [RW-1:0] gain_p_r, gain_i_r, gain_d_r, integ_limit_r, out_limit_r;
  logic [RW-1:0] thresh_a_r, thresh_b_r;
  logic          vary_en_r;

  pvir_pkg::state_t state_r, state_nxt;

  logic signed [DW-1:0]   err_r, eprev_r, iacc_r, drive_r;
  logic signed [TW-1:0]   p_r, d_r;
  logic signed [TW:0]     pd_r;
  logic signed [IW-1:0]   item_r;
  logic                   out_tvalid_r;
  logic [63:0]            out_tdata_r;

  logic signed [DW:0]     diff_in;
  logic signed [DW-1:0]   err_in;
  logic signed [DW:0]     esum, edif;
  logic [DW-1:0]          mag;
  logic [DW-1:0]          ta_tb;
  logic [DW-1:0]          num_w;
  logic                   same_sign, in_full, in_fade, scale_go, out_free;
  logic signed [TW-1:0]   isum;
  logic signed [SW-1:0]   osum;

  pvir_pkg::mac_op_t           mac_op;
  logic signed [AW-1:0]        mac_a;
  logic [BW-1:0]               mac_b;
  logic signed [pvir_pkg::ACC_W-1:0] mac_acc;
  logic                        div_start;
  logic [pvir_pkg::DIV_Q_W-1:0] factor;
  pvir_pkg::div_stat_t         div_st;

  pvir_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  pvir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_w[RW-1:0]),
    .den   (thresh_b_r),
    .quot  (factor),
    .stat  (div_st)
  );

  // error, saturated to 32 bits
  assign diff_in = $signed({in_tdata[31], in_tdata[31:0]}) -
                   $signed({in_tdata[63], in_tdata[63:32]});
  always_comb begin
    if (diff_in[DW] != diff_in[DW-1]) begin
      err_in = diff_in[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      err_in = diff_in[DW-1:0];
    end
  end

  assign esum = {err_r[DW-1], err_r} + {eprev_r[DW-1], eprev_r};
  assign edif = {err_r[DW-1], err_r} - {eprev_r[DW-1], eprev_r};

  // rate scaling decision
  assign mag       = err_r[DW-1] ? -err_r : err_r;
  assign ta_tb     = {1'b0, thresh_a_r} + {1'b0, thresh_b_r};
  assign num_w     = ta_tb - mag;
  assign same_sign = (!err_r[DW-1] && (|err_r) && !iacc_r[DW-1] && (|iacc_r)) ||
                     (err_r[DW-1] && iacc_r[DW-1]);
  assign in_full   = mag <= {1'b0, thresh_a_r};
  assign in_fade   = mag <= ta_tb;
  assign scale_go  = vary_en_r && same_sign && !in_full;

  assign isum = $signed({{(TW-DW){iacc_r[DW-1]}}, iacc_r}) +
                $signed({item_r[IW-1], item_r});
  assign osum = $signed({pd_r[TW], pd_r}) +
                $signed({{(SW-DW){iacc_r[DW-1]}}, iacc_r});

  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pvir_pkg::S_IDLE: if (in_tvalid) state_nxt = pvir_pkg::S_P0;
      pvir_pkg::S_P0:   state_nxt = pvir_pkg::S_P1;
      pvir_pkg::S_P1:   state_nxt = pvir_pkg::S_I0;
      pvir_pkg::S_I0:   state_nxt = pvir_pkg::S_I1;
      pvir_pkg::S_I1:   state_nxt = pvir_pkg::S_D0;
      pvir_pkg::S_D0:   state_nxt = pvir_pkg::S_D1;
      pvir_pkg::S_D1:   state_nxt = pvir_pkg::S_VR;
      pvir_pkg::S_VR: begin
        if (scale_go && in_fade) state_nxt = pvir_pkg::S_DIV;
        else                     state_nxt = pvir_pkg::S_INT;
      end
      pvir_pkg::S_DIV:  if (div_st.done) state_nxt = pvir_pkg::S_SC;
      pvir_pkg::S_SC:   state_nxt = pvir_pkg::S_SCW;
      pvir_pkg::S_SCW:  state_nxt = pvir_pkg::S_INT;
      pvir_pkg::S_INT:  state_nxt = pvir_pkg::S_SUM;
      pvir_pkg::S_SUM:  state_nxt = pvir_pkg::S_OUT;
      pvir_pkg::S_OUT:  if (out_free) state_nxt = pvir_pkg::S_IDLE;
      default:          state_nxt = pvir_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider start and input ready
  always_comb begin
    mac_op    = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      pvir_pkg::S_IDLE: in_tready = 1'b1;
      pvir_pkg::S_P0: begin
        mac_op = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a  = {{(AW-DW){err_r[DW-1]}}, err_r};
        mac_b  = gain_p_r[BW-1:0];
      end
      pvir_pkg::S_P1: begin
        mac_op = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a  = {{(AW-DW){err_r[DW-1]}}, err_r};
        mac_b  = {1'b0, gain_p_r[RW-1:BW]};
      end
      pvir_pkg::S_I0: begin
        mac_op = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a  = {{(AW-DW-1){esum[DW]}}, esum};
        mac_b  = gain_i_r[BW-1:0];
      end
      pvir_pkg::S_I1: begin
        mac_op = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a  = {{(AW-DW-1){esum[DW]}}, esum};
        mac_b  = {1'b0, gain_i_r[RW-1:BW]};
      end
      pvir_pkg::S_D0: begin
        mac_op = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a  = {{(AW-DW-1){edif[DW]}}, edif};
        mac_b  = gain_d_r[BW-1:0];
      end
      pvir_pkg::S_D1: begin
        mac_op = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a  = {{(AW-DW-1){edif[DW]}}, edif};
        mac_b  = {1'b0, gain_d_r[RW-1:BW]};
      end
      pvir_pkg::S_VR:   div_start = scale_go && in_fade;
      pvir_pkg::S_SC: begin
        mac_op = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a  = {{(AW-IW){item_r[IW-1]}}, item_r};
        mac_b  = factor;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvir_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      integ_limit_r <= '0;
      out_limit_r   <= '0;
      vary_en_r     <= 1'b0;
      thresh_a_r    <= '0;
      thresh_b_r    <= '0;
    end else if (cfg_wr_en) begin
      case (pvir_pkg::cfg_reg_t'(cfg_addr))
        pvir_pkg::REG_GAIN_P:      gain_p_r      <= cfg_wdata;
        pvir_pkg::REG_GAIN_I:      gain_i_r      <= cfg_wdata;
        pvir_pkg::REG_GAIN_D:      gain_d_r      <= cfg_wdata;
        pvir_pkg::REG_INTEG_LIMIT: integ_limit_r <= cfg_wdata;
        pvir_pkg::REG_OUT_LIMIT:   out_limit_r   <= cfg_wdata;
        pvir_pkg::REG_VARY_EN:     vary_en_r     <= cfg_wdata[0];
        pvir_pkg::REG_THRESH_A:    thresh_a_r    <= cfg_wdata;
        pvir_pkg::REG_THRESH_B:    thresh_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // controller state: error history and integral
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eprev_r <= '0;
      iacc_r  <= '0;
    end else if (state_r == pvir_pkg::S_INT) begin
      eprev_r <= err_r;
      iacc_r  <= pvir_pkg::clamp_sym({{(SW-TW){isum[TW-1]}}, isum}, integ_limit_r);
    end
  end

  // working registers; products are floored by dropping low bits
  always_ff @(posedge clk) begin
    case (state_r)
      pvir_pkg::S_IDLE: if (in_tvalid) err_r <= err_in;
      pvir_pkg::S_I0:   p_r    <= mac_acc[FW+TW-1:FW];
      pvir_pkg::S_D0:   item_r <= mac_acc[FW+IW:FW+1];
      pvir_pkg::S_VR: begin
        d_r <= mac_acc[FW+TW-1:FW];
        if (scale_go && !in_fade) item_r <= '0;
      end
      pvir_pkg::S_SCW:  item_r <= mac_acc[FW+IW-1:FW];
      pvir_pkg::S_INT:  pd_r   <= {p_r[TW-1], p_r} + {d_r[TW-1], d_r};
      pvir_pkg::S_SUM:  drive_r <= pvir_pkg::clamp_sym(osum, out_limit_r);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == pvir_pkg::S_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pvir_pkg::S_OUT && out_free) begin
      out_tdata_r <= {iacc_r, drive_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> state_r == pvir_pkg::S_DIV)
    else $error("divider busy outside the division step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == pvir_pkg::S_P0)
    else $error("accepted item did not start the sequence");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == pvir_pkg::S_OUT))
    else $error("output item raised outside the hand-over step");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy && thresh_b_r != '0)
    else $error("divider started while busy or with zero fade width");

endmodule

// File: design/pvir_mac.sv
// Shared multiply-accumulate unit: signed 49-bit by unsigned 16-bit chunk,
// optional 16-bit weighting, 64-bit accumulator. Depends on pvir_pkg.
`timescale 1ns / 1ps

module pvir_mac (
  input  logic                                clk,
  input  pvir_pkg::mac_op_t                   op,
  input  logic signed [pvir_pkg::MUL_A_W-1:0] a,
  input  logic [pvir_pkg::MUL_B_W-1:0]        b,
  output logic signed [pvir_pkg::ACC_W-1:0]   acc
);

  localparam int PROD_W = pvir_pkg::MUL_A_W + pvir_pkg::MUL_B_W + 1;

  logic signed [PROD_W-1:0]          prod;
  logic signed [pvir_pkg::ACC_W-1:0] term;
  logic signed [pvir_pkg::ACC_W-1:0] acc_r;
  logic signed [pvir_pkg::ACC_W-1:0] acc_nxt;

  assign prod = a * $signed({1'b0, b});

  always_comb begin
    if (op.shift_hi) begin
      term = prod[pvir_pkg::ACC_W-1:0] <<< pvir_pkg::MUL_B_W;
    end else begin
      term = prod[pvir_pkg::ACC_W-1:0];
    end
    if (op.clear) begin
      acc_nxt = term;
    end else begin
      acc_nxt = acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: design/pvir_div.sv
// Restoring divider for the fade factor: (num << 16) / den with num < den,
// one quotient bit per cycle. Depends on pvir_pkg.
`timescale 1ns / 1ps

module pvir_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pvir_pkg::REG_W-1:0]    num,
  input  logic [pvir_pkg::REG_W-1:0]    den,
  output logic [pvir_pkg::DIV_Q_W-1:0]  quot,
  output pvir_pkg::div_stat_t           stat
);

  logic [pvir_pkg::REG_W-1:0]     rem_r;
  logic [pvir_pkg::REG_W-1:0]     rem_nxt;
  logic [pvir_pkg::DIV_Q_W-1:0]   q_r;
  logic [pvir_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [pvir_pkg::REG_W:0]       rem_sh;
  logic [pvir_pkg::REG_W:0]       rem_sub;
  logic                           ge;

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_nxt = ge ? rem_sub[pvir_pkg::REG_W-1:0] : rem_sh[pvir_pkg::REG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      q_r   <= '0;
      cnt_r <= pvir_pkg::DIV_CNT_W'(pvir_pkg::DIV_Q_W - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[pvir_pkg::DIV_Q_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);

endmodule
